### hw/rtl/mowd_pkg.sv
// shared types and constants for the object word decoder
package mowd_pkg;

	// default width of the running item counter
	localparam int COUNT_BITS_DEF = 16;

	// relocatable image cookie and header length
	localparam logic [31:0] MERL_COOKIE  = 32'h1000_0002;
	localparam logic [31:0] HEADER_WORDS = 32'd3;

	// word field widths
	localparam int REG_W  = 5;
	localparam int IMM_W  = 16;
	localparam int JMP_W  = 28;
	localparam int IDX_W  = 16;
	localparam int WORD_W = 32;

	// opcode and funct codes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_ADD   = 6'd32;
	localparam logic [5:0] FN_SUB   = 6'd34;
	localparam logic [5:0] FN_MULT  = 6'd24;
	localparam logic [5:0] FN_MULTU = 6'd25;
	localparam logic [5:0] FN_DIV   = 6'd26;
	localparam logic [5:0] FN_DIVU  = 6'd27;
	localparam logic [5:0] FN_MFHI  = 6'd16;
	localparam logic [5:0] FN_MFLO  = 6'd18;
	localparam logic [5:0] FN_LIS   = 6'd20;
	localparam logic [5:0] FN_JR    = 6'd8;
	localparam logic [5:0] FN_JALR  = 6'd9;
	localparam logic [5:0] FN_SLT   = 6'd42;
	localparam logic [5:0] FN_SLTU  = 6'd43;

	typedef enum logic [2:0] {
		RGN_COOKIE   = 3'd0,
		RGN_FILE_END = 3'd1,
		RGN_CODE_END = 3'd2,
		RGN_INSTR    = 3'd3,
		RGN_LITERAL  = 3'd4,
		RGN_RELOC    = 3'd5
	} region_t;

	typedef enum logic [4:0] {
		K_ADD    = 5'd0,
		K_SUB    = 5'd1,
		K_MULT   = 5'd2,
		K_MULTU  = 5'd3,
		K_DIV    = 5'd4,
		K_DIVU   = 5'd5,
		K_MFHI   = 5'd6,
		K_MFLO   = 5'd7,
		K_LIS    = 5'd8,
		K_JR     = 5'd9,
		K_JALR   = 5'd10,
		K_SLT    = 5'd11,
		K_SLTU   = 5'd12,
		K_BEQ    = 5'd13,
		K_BNE    = 5'd14,
		K_LW     = 5'd15,
		K_SW     = 5'd16,
		K_J      = 5'd17,
		K_JAL    = 5'd18,
		K_BAD_FN = 5'd19,
		K_BAD_OP = 5'd20
	} kind_t;

	// decoded fields of one code word
	typedef struct packed {
		kind_t              kind;
		logic [REG_W-1:0]   src_reg;
		logic [REG_W-1:0]   tgt_reg;
		logic [REG_W-1:0]   dst_reg;
		logic [IMM_W-1:0]   immediate;
		logic [JMP_W-1:0]   jump_target;
		logic [WORD_W-1:0]  word_echo;
	} decode_t;

	// classification of one word by the position tracker
	typedef struct packed {
		region_t            region;
		logic [IDX_W-1:0]   item_index;
	} track_t;

endpackage

### hw/rtl/mowd_ifs.sv
// word channel interfaces for the object word decoder

interface mowd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        start_req;

	modport source (output valid, output data_word, output start_req, input ready);
	modport sink   (input valid, input data_word, input start_req, output ready);
endinterface

interface mowd_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         region;
	logic [4:0]         kind;
	logic [4:0]         src_reg;
	logic [4:0]         tgt_reg;
	logic [4:0]         dst_reg;
	logic signed [15:0] immediate;
	logic [27:0]        jump_target;
	logic [15:0]        item_index;
	logic [31:0]        word_echo;

	modport source (output valid, output region, output kind, output src_reg,
		output tgt_reg, output dst_reg, output immediate, output jump_target,
		output item_index, output word_echo, input ready);
	modport sink (input valid, input region, input kind, input src_reg,
		input tgt_reg, input dst_reg, input immediate, input jump_target,
		input item_index, input word_echo, output ready);
endinterface

### hw/rtl/mowd_decode.sv
// instruction field decode of one code word
module mowd_decode
	import mowd_pkg::*;
(
	input  logic [WORD_W-1:0] word,
	output decode_t           dec
);

	logic [5:0] op;
	logic [5:0] fn;
	kind_t      kind;
	logic       has_imm;
	logic       has_jump;

	assign op = word[31:26];
	assign fn = word[5:0];

	// opcode and funct lookup
	always_comb begin
		has_imm  = 1'b0;
		has_jump = 1'b0;
		kind     = K_BAD_OP;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_ADD:   kind = K_ADD;
					FN_SUB:   kind = K_SUB;
					FN_MULT:  kind = K_MULT;
					FN_MULTU: kind = K_MULTU;
					FN_DIV:   kind = K_DIV;
					FN_DIVU:  kind = K_DIVU;
					FN_MFHI:  kind = K_MFHI;
					FN_MFLO:  kind = K_MFLO;
					FN_LIS:   kind = K_LIS;
					FN_JR:    kind = K_JR;
					FN_JALR:  kind = K_JALR;
					FN_SLT:   kind = K_SLT;
					FN_SLTU:  kind = K_SLTU;
					default:  kind = K_BAD_FN;
				endcase
			end
			OP_BEQ: begin kind = K_BEQ; has_imm = 1'b1; end
			OP_BNE: begin kind = K_BNE; has_imm = 1'b1; end
			OP_LW:  begin kind = K_LW;  has_imm = 1'b1; end
			OP_SW:  begin kind = K_SW;  has_imm = 1'b1; end
			OP_J:   begin kind = K_J;   has_jump = 1'b1; end
			OP_JAL: begin kind = K_JAL; has_jump = 1'b1; end
			default: kind = K_BAD_OP;
		endcase
	end

	// field extraction
	always_comb begin
		dec.kind        = kind;
		dec.src_reg     = word[25:21];
		dec.tgt_reg     = word[20:16];
		dec.dst_reg     = word[15:11];
		dec.immediate   = has_imm ? word[15:0] : '0;
		dec.jump_target = has_jump ? {word[25:0], 2'b00} : '0;
		dec.word_echo   = (kind == K_BAD_FN || kind == K_BAD_OP) ? word : '0;
	end

endmodule

### hw/rtl/mowd_tracker.sv
// image position, mode and item count tracking
module mowd_tracker
	import mowd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [WORD_W-1:0] word,
	input  logic              start_req,
	input  logic              is_lis,
	output track_t            trk
);

	logic                  mode_q;
	logic [31:0]           pos_q;
	logic [31:0]           code_end_q;
	logic                  lit_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic                  start;
	logic                  mode;
	logic [31:0]           pos;
	logic                  lit;
	logic [COUNT_BITS-1:0] cnt;
	logic [31:0]           pos_prev;
	logic                  hdr;
	logic                  in_code;
	logic                  prev_code;
	logic                  lit_nxt;
	logic [COUNT_BITS-1:0] cnt_base;
	logic [COUNT_BITS-1:0] cnt_nxt;

	// image restart on start flag or first word after reset
	assign start    = start_req || (pos_q == '0);
	assign mode     = start ? (word == MERL_COOKIE) : mode_q;
	assign pos      = start ? '0 : pos_q;
	assign lit      = start ? 1'b0 : lit_q;
	assign cnt      = start ? '0 : cnt_q;
	assign pos_prev = pos - 32'd1;

	// byte offset compares against end of code
	assign hdr       = mode && (pos < HEADER_WORDS);
	assign in_code   = {pos, 2'b00} < {2'b00, code_end_q};
	assign prev_code = {pos_prev, 2'b00} < {2'b00, code_end_q};

	// region and count selection
	always_comb begin
		trk.region     = RGN_INSTR;
		trk.item_index = '0;
		lit_nxt        = lit;
		cnt_base       = cnt;
		cnt_nxt        = cnt;
		if (hdr) begin
			trk.region = region_t'({1'b0, pos[1:0]});
		end else if (mode && !in_code) begin
			if (pos == HEADER_WORDS || prev_code) begin
				cnt_base = '0;
			end
			lit_nxt        = 1'b0;
			trk.region     = RGN_RELOC;
			trk.item_index = IDX_W'(cnt_base);
			cnt_nxt        = cnt_base + 1'b1;
		end else begin
			if (lit) begin
				trk.region = RGN_LITERAL;
				lit_nxt    = 1'b0;
			end else begin
				trk.region = RGN_INSTR;
				lit_nxt    = is_lis;
			end
			trk.item_index = IDX_W'(cnt);
			cnt_nxt        = cnt + 1'b1;
		end
	end

	// state update once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			pos_q      <= '0;
			code_end_q <= '0;
			lit_q      <= 1'b0;
			cnt_q      <= '0;
		end else if (adv) begin
			mode_q <= mode;
			pos_q  <= (pos == '1) ? pos : pos + 32'd1;
			lit_q  <= lit_nxt;
			cnt_q  <= cnt_nxt;
			if (hdr && pos == 32'd2) begin
				code_end_q <= word;
			end
		end
	end

endmodule

### hw/rtl/mips_object_word_decoder.sv
// Streaming decoder for object image words; a result is valid once its word has passed the
// input, then result registers; throughput one word per cycle while decoded.ready is high.
// The position state updates as a word moves from the input to the result register;
// a held result register keeps the input register full, which then drops ready.
// Reset (arst_n low) clears valid flags, position, mode, code end, literal mark and count.
// After reset the first word is taken as the start of an image.
module mips_object_word_decoder
	import mowd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	mowd_in_if.sink  image,
	mowd_out_if.source decoded
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              start_s1;
	logic              adv;
	logic              out_valid_q;
	decode_t           dec;
	track_t            trk;
	logic              is_code;

	// pipeline flow control
	assign adv         = valid_s1 && (!out_valid_q || decoded.ready);
	assign image.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (image.ready && image.valid) begin
			word_s1  <= image.data_word;
			start_s1 <= image.start_req;
		end
	end

	mowd_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	mowd_tracker #(
		.COUNT_BITS (COUNT_BITS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.word      (word_s1),
		.start_req (start_s1),
		.is_lis    (dec.kind == K_LIS),
		.trk       (trk)
	);

	assign is_code = (trk.region == RGN_INSTR);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			decoded.region      <= trk.region;
			decoded.kind        <= is_code ? dec.kind : K_ADD;
			decoded.src_reg     <= is_code ? dec.src_reg : '0;
			decoded.tgt_reg     <= is_code ? dec.tgt_reg : '0;
			decoded.dst_reg     <= is_code ? dec.dst_reg : '0;
			decoded.immediate   <= is_code ? dec.immediate : '0;
			decoded.jump_target <= is_code ? dec.jump_target : '0;
			decoded.item_index  <= trk.item_index;
			decoded.word_echo   <= is_code ? dec.word_echo : word_s1;
		end
	end

	assign decoded.valid = out_valid_q;

endmodule
